@@ sv/sat_pkg.sv @@
// Shared types and codes for the socket association table.
`default_nettype none
package sat_pkg;

  localparam logic [2:0] FUNC_UPSERT = 3'd0;
  localparam logic [2:0] FUNC_SET_REMOTE = 3'd1;
  localparam logic [2:0] FUNC_LOOKUP = 3'd2;
  localparam logic [2:0] FUNC_FIND_PORT = 3'd3;
  localparam logic [2:0] FUNC_FORGET = 3'd4;

  localparam logic [4:0] DGRAM_CODE = 5'd2;

  // One table slot. The handle is stored already masked to the key width.
  typedef struct packed {
    logic        valid;
    logic [31:0] handle;
    logic [15:0] port;
    logic        port_known;
    logic [4:0]  sock_type;
    logic        connected;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic free;
  } cmp_res_t;

endpackage
`default_nettype wire

@@ sv/sat_mem.sv @@
// Table storage: one write port, one read port with registered read data.
`default_nettype none
module sat_mem #(
  parameter int DEPTH = 128,
  parameter int ADDR_BITS = 7
) (
  input  wire                    clk_i,
  input  wire                    we_i,
  input  wire  [ADDR_BITS-1:0]   waddr_i,
  input  sat_pkg::entry_t        wdata_i,
  input  wire  [ADDR_BITS-1:0]   raddr_i,
  output sat_pkg::entry_t        rdata_o
);
  import sat_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/sat_cmp.sv @@
// Shared slot compare unit: key or port match, and free-slot detect.
`default_nettype none
module sat_cmp (
  input  sat_pkg::entry_t    entry_i,
  input  wire                by_port_i,
  input  wire  [31:0]        key_i,
  input  wire  [15:0]        port_i,
  output sat_pkg::cmp_res_t  res_o
);
  import sat_pkg::*;

  logic key_eq;
  logic port_eq;

  assign key_eq  = entry_i.handle == key_i;
  // port_known implies a nonzero port, so port 0 never matches
  assign port_eq = entry_i.port_known && (entry_i.port == port_i);

  assign res_o.hit  = entry_i.valid && (by_port_i ? port_eq : key_eq);
  assign res_o.free = !entry_i.valid;

endmodule
`default_nettype wire

@@ sv/socket_association_table_core.sv @@
// Socket association table: sequencer scanning the slot memory one entry per cycle.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+------------------------------
//  command   | func_i, sock_handle_i, local_port_in_i, | word taken when start_i && !busy_o
//            | sock_type_i, peer_ip_in_i, peer_port_in_i |
//  result    | hit_o .. dropped_o                     | word valid while done_o is high
//
//  After reset a clearing pass writes every slot, with busy_o high.
//  An item scans slots from 0 upward, one memory read per cycle; the scan stops at the
//  first match, or after the last slot when nothing matches, and a finish step then
//  raises done_o; the next word can be taken in the strobe cycle.
//  busy_o stays high until the result strobe; the receiver cannot stall the result.
`default_nettype none
module socket_association_table_core #(
  parameter int TABLE_ENTRIES = 128,
  parameter int HANDLE_BITS = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  output logic              busy_o,
  input  wire        [2:0]  func_i,
  input  wire        [31:0] sock_handle_i,
  input  wire        [15:0] local_port_in_i,
  input  wire signed [4:0]  sock_type_i,
  input  wire        [31:0] peer_ip_in_i,
  input  wire        [15:0] peer_port_in_i,
  output logic              done_o,
  output logic              hit_o,
  output logic       [31:0] found_handle_o,
  output logic       [15:0] local_port_out_o,
  output logic              port_known_o,
  output logic              is_datagram_o,
  output logic              is_connected_o,
  output logic       [31:0] peer_ip_out_o,
  output logic       [15:0] peer_port_out_o,
  output logic              dropped_o
);
  import sat_pkg::*;

  localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);
  localparam logic [31:0] KEY_MASK = (HANDLE_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << HANDLE_BITS) - 64'd1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                rd_vld_q, rd_vld_d;
  logic [IDX_BITS-1:0] rd_idx_q;
  logic                found_q, found_d;
  logic                free_found_q, free_found_d;
  logic [IDX_BITS-1:0] idx_q;
  logic [IDX_BITS-1:0] free_idx_q;
  entry_t              ent_q;

  // latched command word
  logic [2:0]  func_q;
  logic [31:0] key_q;
  logic [15:0] port_q;
  logic [4:0]  type_q;
  logic [31:0] pip_q;
  logic [15:0] pport_q;

  // result registers
  logic        done_q;
  logic        hit_q;
  logic        dropped_q;
  entry_t      rep_q;

  logic                accept;
  logic                issue;
  logic                last_rd;
  logic                mem_we;
  logic [IDX_BITS-1:0] mem_waddr;
  entry_t              mem_wdata;
  entry_t              rd_data;
  cmp_res_t            cmp;

  logic                fin_we;
  logic [IDX_BITS-1:0] fin_waddr;
  entry_t              fin_ent;
  logic                fin_rep;
  logic                fin_hit;
  logic                fin_drop;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign issue   = (state_q == ST_SCAN) && (cnt_q < CNT_BITS'(TABLE_ENTRIES));
  assign last_rd = rd_idx_q == IDX_BITS'(TABLE_ENTRIES - 1);

  sat_mem #(
    .DEPTH     (TABLE_ENTRIES),
    .ADDR_BITS (IDX_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (cnt_q[IDX_BITS-1:0]),
    .rdata_o (rd_data)
  );

  sat_cmp u_cmp (
    .entry_i   (rd_data),
    .by_port_i (func_q == FUNC_FIND_PORT),
    .key_i     (key_q),
    .port_i    (port_q),
    .res_o     (cmp)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    found_d      = found_q;
    free_found_d = free_found_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_BITS'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d      = ST_SCAN;
          cnt_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
        end
      end
      ST_SCAN: begin
        rd_vld_d = issue;
        if (issue) begin
          cnt_d = cnt_q + CNT_BITS'(1);
        end
        if (rd_vld_q) begin
          if (cmp.free) begin
            free_found_d = 1'b1;
          end
          if (cmp.hit) begin
            found_d = 1'b1;
            state_d = ST_FINISH;
          end else if (last_rd) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // final update and report for the latched command
  always_comb begin
    fin_we    = 1'b0;
    fin_waddr = idx_q;
    fin_ent   = ent_q;
    fin_rep   = 1'b0;
    fin_hit   = 1'b0;
    fin_drop  = 1'b0;
    case (func_q)
      FUNC_UPSERT: begin
        if (found_q) begin
          if (port_q != 16'd0) begin
            fin_ent.port       = port_q;
            fin_ent.port_known = 1'b1;
          end
          if (!type_q[4]) begin
            fin_ent.sock_type = type_q;
          end
          fin_we  = 1'b1;
          fin_rep = 1'b1;
          fin_hit = 1'b1;
        end else if (free_found_q) begin
          fin_ent.valid      = 1'b1;
          fin_ent.handle     = key_q;
          fin_ent.port       = port_q;
          fin_ent.port_known = port_q != 16'd0;
          fin_ent.sock_type  = type_q;
          fin_ent.connected  = 1'b0;
          fin_ent.peer_ip    = 32'd0;
          fin_ent.peer_port  = 16'd0;
          fin_waddr          = free_idx_q;
          fin_we             = 1'b1;
          fin_rep            = 1'b1;
        end else begin
          fin_drop = 1'b1;
        end
      end
      FUNC_SET_REMOTE: begin
        if (found_q) begin
          fin_ent.connected = 1'b1;
          fin_ent.peer_ip   = pip_q;
          fin_ent.peer_port = pport_q;
          fin_we            = 1'b1;
          fin_rep           = 1'b1;
          fin_hit           = 1'b1;
        end
      end
      FUNC_LOOKUP, FUNC_FIND_PORT: begin
        fin_rep = found_q;
        fin_hit = found_q;
      end
      FUNC_FORGET: begin
        if (found_q) begin
          fin_ent.valid      = 1'b0;
          fin_ent.port       = 16'd0;
          fin_ent.port_known = 1'b0;
          fin_we             = 1'b1;
          fin_hit            = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // memory write port: clearing pass or final update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fin_waddr;
    mem_wdata = fin_ent;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[IDX_BITS-1:0];
      mem_wdata = '0;
    end else if (state_q == ST_FINISH) begin
      mem_we = fin_we;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rd_vld_q     <= rd_vld_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      done_q       <= state_q == ST_FINISH;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IDX_BITS-1:0];
    if (accept) begin
      func_q  <= func_i;
      key_q   <= sock_handle_i & KEY_MASK;
      port_q  <= local_port_in_i;
      type_q  <= sock_type_i;
      pip_q   <= peer_ip_in_i;
      pport_q <= peer_port_in_i;
    end
    if (state_q == ST_SCAN && rd_vld_q) begin
      if (cmp.hit) begin
        idx_q <= rd_idx_q;
        ent_q <= rd_data;
      end
      if (cmp.free && !free_found_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
    if (state_q == ST_FINISH) begin
      hit_q     <= fin_hit;
      dropped_q <= fin_drop;
      rep_q     <= fin_rep ? fin_ent : '0;
    end
  end

  assign busy_o           = state_q != ST_IDLE;
  assign done_o           = done_q;
  assign hit_o            = hit_q;
  assign dropped_o        = dropped_q;
  assign found_handle_o   = rep_q.handle;
  assign local_port_out_o = rep_q.port_known ? rep_q.port : 16'd0;
  assign port_known_o     = rep_q.port_known;
  assign is_datagram_o    = rep_q.sock_type == DGRAM_CODE;
  assign is_connected_o   = rep_q.connected;
  assign peer_ip_out_o    = rep_q.peer_ip;
  assign peer_port_out_o  = rep_q.peer_port;

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == ST_FINISH)
    else $error("result strobe without a finish step");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> state_q == ST_SCAN)
    else $error("accepted word did not start a scan");

  a_drop_only_upsert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dropped_q) |-> (func_q == FUNC_UPSERT && !hit_q))
    else $error("dropped flagged outside a missed upsert");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_FINISH))
    else $error("table write outside clear or finish");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the socket association table core: directed, full-table and random runs.
`default_nettype none
module tb;
  import sat_pkg::*;

  localparam int TABLE_ENTRIES = 128;
  localparam int HANDLE_BITS = 32;
  localparam logic [31:0] HANDLE_MASK = (HANDLE_BITS >= 32) ? 32'hFFFF_FFFF :
                                        ((32'd1 << HANDLE_BITS) - 32'd1);
  localparam int IDLE_PCT = 6;
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 8;
  localparam logic [31:0] HANDLE_STRIDE = 32'h0100_0193;
  localparam int POOL_MAX = 200;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_handle;
    logic [15:0] local_port;
    logic        port_known;
    logic        is_datagram;
    logic        is_connected;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic        dropped;
  } sock_result_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  func_i = FUNC_LOOKUP;
  logic [31:0] sock_handle_i = '0;
  logic [15:0] local_port_in_i = '0;
  logic [4:0]  sock_type_i = '0;
  logic [31:0] peer_ip_in_i = '0;
  logic [15:0] peer_port_in_i = '0;

  logic        busy_o;
  logic        done_o;
  logic        hit_o;
  logic [31:0] found_handle_o;
  logic [15:0] local_port_out_o;
  logic        port_known_o;
  logic        is_datagram_o;
  logic        is_connected_o;
  logic [31:0] peer_ip_out_o;
  logic [15:0] peer_port_out_o;
  logic        dropped_o;

  socket_association_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .HANDLE_BITS  (HANDLE_BITS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .sock_handle_i   (sock_handle_i),
    .local_port_in_i (local_port_in_i),
    .sock_type_i     (sock_type_i),
    .peer_ip_in_i    (peer_ip_in_i),
    .peer_port_in_i  (peer_port_in_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .found_handle_o  (found_handle_o),
    .local_port_out_o(local_port_out_o),
    .port_known_o    (port_known_o),
    .is_datagram_o   (is_datagram_o),
    .is_connected_o  (is_connected_o),
    .peer_ip_out_o   (peer_ip_out_o),
    .peer_port_out_o (peer_port_out_o),
    .dropped_o       (dropped_o)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the slot table
  logic        tbl_valid     [TABLE_ENTRIES];
  logic [31:0] tbl_handle    [TABLE_ENTRIES];
  logic [15:0] tbl_port      [TABLE_ENTRIES];
  logic        tbl_known     [TABLE_ENTRIES];
  logic [4:0]  tbl_type      [TABLE_ENTRIES];
  logic        tbl_connected [TABLE_ENTRIES];
  logic [31:0] tbl_peer_ip   [TABLE_ENTRIES];
  logic [15:0] tbl_peer_port [TABLE_ENTRIES];

  sock_result_t pending_results[$];
  int           errors = 0;
  bit           idle_enable = 1'b1;
  logic [31:0]  handle_pool [POOL_MAX];
  logic [15:0]  port_pool [16];

  function automatic int match_slot(input logic [31:0] key);
    int slot;
    slot = -1;
    for (int k = 0; k < TABLE_ENTRIES; k++)
      if (slot < 0 && tbl_valid[k] && (tbl_handle[k] & HANDLE_MASK) == key) slot = k;
    return slot;
  endfunction

  function automatic sock_result_t predict_socket_op(
    input logic [2:0]  func,
    input logic [31:0] handle,
    input logic [15:0] port,
    input logic [4:0]  stype,
    input logic [31:0] pip,
    input logic [15:0] pport
  );
    sock_result_t res;
    logic [31:0]  key;
    int           slot;
    res = '0;
    key = handle & HANDLE_MASK;
    slot = -1;
    case (func)
      FUNC_UPSERT: begin
        slot = match_slot(key);
        if (slot >= 0) begin
          if (port != 16'd0) begin
            tbl_port[slot] = port;
            tbl_known[slot] = 1'b1;
          end
          if (!stype[4]) tbl_type[slot] = stype;  // negative type keeps the stored one
          res.hit = 1'b1;
        end else begin
          for (int k = 0; k < TABLE_ENTRIES; k++)
            if (slot < 0 && !tbl_valid[k]) slot = k;
          if (slot >= 0) begin
            tbl_valid[slot] = 1'b1;
            tbl_handle[slot] = key;
            tbl_port[slot] = port;
            tbl_known[slot] = (port != 16'd0);
            tbl_type[slot] = stype;
            tbl_connected[slot] = 1'b0;
            tbl_peer_ip[slot] = '0;
            tbl_peer_port[slot] = '0;
          end else begin
            res.dropped = 1'b1;
          end
        end
      end
      FUNC_SET_REMOTE: begin
        slot = match_slot(key);
        if (slot >= 0) begin
          tbl_connected[slot] = 1'b1;
          tbl_peer_ip[slot] = pip;
          tbl_peer_port[slot] = pport;
          res.hit = 1'b1;
        end
      end
      FUNC_LOOKUP: begin
        slot = match_slot(key);
        if (slot >= 0) res.hit = 1'b1;
      end
      FUNC_FIND_PORT: begin
        for (int k = 0; k < TABLE_ENTRIES; k++)
          if (slot < 0 && tbl_valid[k] && tbl_known[k] && tbl_port[k] == port) slot = k;
        if (slot >= 0) res.hit = 1'b1;
      end
      FUNC_FORGET: begin
        slot = match_slot(key);
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b0;
          tbl_port[slot] = '0;
          tbl_known[slot] = 1'b0;
          res.hit = 1'b1;
        end
        slot = -1;  // forget reports hit only
      end
      default: ;
    endcase
    if (slot >= 0) begin
      res.found_handle = tbl_handle[slot];
      res.local_port = tbl_known[slot] ? tbl_port[slot] : 16'd0;
      res.port_known = tbl_known[slot];
      res.is_datagram = (tbl_type[slot] == DGRAM_CODE);
      res.is_connected = tbl_connected[slot];
      res.peer_ip = tbl_peer_ip[slot];
      res.peer_port = tbl_peer_port[slot];
    end
    return res;
  endfunction

  // called at a rising edge; returns at the edge that took the word
  task automatic send_word(
    input logic [2:0]  func,
    input logic [31:0] handle,
    input logic [15:0] port,
    input logic [4:0]  stype,
    input logic [31:0] pip,
    input logic [15:0] pport
  );
    if (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    func_i <= func;
    sock_handle_i <= handle;
    local_port_in_i <= port;
    sock_type_i <= stype;
    peer_ip_in_i <= pip;
    peer_port_in_i <= pport;
    start_i <= 1'b1;
    @(posedge clk);
    while (busy_o) @(posedge clk);
    pending_results.push_back(predict_socket_op(func, handle, port, stype, pip, pport));
  endtask

  task automatic wait_drained;
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    sock_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing pending, expected none, actual hit=%0b",
                 $time, hit_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("hit", want.hit, hit_o);
        compare_field("found_handle", want.found_handle, found_handle_o);
        compare_field("local_port", want.local_port, local_port_out_o);
        compare_field("port_known", want.port_known, port_known_o);
        compare_field("is_datagram", want.is_datagram, is_datagram_o);
        compare_field("is_connected", want.is_connected, is_connected_o);
        compare_field("peer_ip", want.peer_ip, peer_ip_out_o);
        compare_field("peer_port", want.peer_port, peer_port_out_o);
        compare_field("dropped", want.dropped, dropped_o);
      end
    end
  end

  task automatic test_basic_ops;
    logic [31:0] h_a;
    logic [31:0] h_b;
    logic [31:0] h_c;
    h_a = 32'h0000_0000;
    h_b = 32'hFFFF_FFFF;
    h_c = 32'h1234_5678;
    // misses on an empty table
    send_word(FUNC_LOOKUP, h_a, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_FIND_PORT, h_a, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_FORGET, h_b, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_SET_REMOTE, h_b, 16'd0, 5'd0, 32'hFFFF_FFFF, 16'hFFFF);
    // claim with unknown port and negative type
    send_word(FUNC_UPSERT, h_a, 16'd0, 5'h1F, '0, '0);
    send_word(FUNC_FIND_PORT, h_a, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_UPSERT, h_b, 16'hFFFF, DGRAM_CODE, '0, '0);
    // match: zero port keeps port, then new port with negative type keeps type
    send_word(FUNC_UPSERT, h_a, 16'd0, DGRAM_CODE, '0, '0);
    send_word(FUNC_UPSERT, h_a, 16'd1, 5'h10, '0, '0);
    send_word(FUNC_SET_REMOTE, h_b, 16'd0, 5'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(FUNC_SET_REMOTE, h_a, 16'hFFFF, 5'h1F, 32'h0, 16'h0);
    send_word(FUNC_LOOKUP, h_b, 16'hFFFF, 5'h1F, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(FUNC_FIND_PORT, h_c, 16'hFFFF, 5'd0, '0, '0);
    send_word(FUNC_FIND_PORT, h_c, 16'd1, 5'd0, '0, '0);
    send_word(FUNC_UPSERT, h_c, 16'd1, 5'd15, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(FUNC_FIND_PORT, h_b, 16'd1, 5'd0, '0, '0);
    send_word(FUNC_FORGET, h_a, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_FORGET, h_a, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_LOOKUP, h_a, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_FIND_PORT, h_a, 16'd1, 5'd0, '0, '0);
    // reclaim of a forgotten slot must come back unconnected
    send_word(FUNC_UPSERT, h_a, 16'd7, 5'd0, '0, '0);
    send_word(FUNC_LOOKUP, h_a, 16'd0, 5'd0, '0, '0);
    for (int f = 1; f <= 3; f++)
      send_word(FUNC_FORGET + 3'(f), h_b, 16'hFFFF, 5'h1F, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(FUNC_LOOKUP, h_b, 16'd0, 5'd0, '0, '0);
    wait_drained();
  endtask

  task automatic test_full_table;
    logic [31:0] base;
    base = $urandom;
    idle_enable = 1'b0;
    send_word(FUNC_FORGET, 32'h0000_0000, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_FORGET, 32'hFFFF_FFFF, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_FORGET, 32'h1234_5678, 16'd0, 5'd0, '0, '0);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_word(FUNC_UPSERT, base + 32'(i) * HANDLE_STRIDE, 16'(i + 1),
                5'($urandom_range(31)), $urandom, 16'($urandom_range(65535)));
    send_word(FUNC_UPSERT, base + 32'(TABLE_ENTRIES) * HANDLE_STRIDE, 16'd5, 5'd2, '0, '0);
    send_word(FUNC_LOOKUP, base + 32'(TABLE_ENTRIES - 1) * HANDLE_STRIDE, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_FIND_PORT, base, 16'(TABLE_ENTRIES), 5'd0, '0, '0);
    send_word(FUNC_FIND_PORT, base, 16'hFFFE, 5'd0, '0, '0);
    send_word(FUNC_UPSERT, base + 32'(TABLE_ENTRIES - 1) * HANDLE_STRIDE, 16'hFFFE,
              DGRAM_CODE, '0, '0);
    send_word(FUNC_SET_REMOTE, base + 32'(TABLE_ENTRIES - 1) * HANDLE_STRIDE, 16'd0, 5'd0,
              $urandom, 16'($urandom_range(65535)));
    send_word(FUNC_FORGET, base + 32'd60 * HANDLE_STRIDE, 16'd0, 5'd0, '0, '0);
    send_word(FUNC_UPSERT, base + 32'(TABLE_ENTRIES) * HANDLE_STRIDE, 16'd0, 5'h1F, '0, '0);
    send_word(FUNC_UPSERT, base + 32'(TABLE_ENTRIES + 1) * HANDLE_STRIDE, 16'd9, 5'd2, '0, '0);
    for (int i = 0; i < TABLE_ENTRIES + 2; i++)
      send_word(FUNC_FORGET, base + 32'(i) * HANDLE_STRIDE, 16'd0, 5'd0, '0, '0);
    idle_enable = 1'b1;
    wait_drained();
  endtask

  task automatic run_segment(input int pool_n, input int forget_pct, input int upsert_pct,
                             input int count);
    logic [2:0]  func;
    logic [31:0] handle;
    logic [15:0] port;
    int          r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 4) func = FUNC_FORGET + 3'($urandom_range(1, 3));
      else if (r < 4 + forget_pct) func = FUNC_FORGET;
      else begin
        r = $urandom_range(99);
        if (r < upsert_pct) func = FUNC_UPSERT;
        else if (r < upsert_pct + (100 - upsert_pct) / 4) func = FUNC_SET_REMOTE;
        else if (r < upsert_pct + (100 - upsert_pct) * 5 / 8) func = FUNC_LOOKUP;
        else func = FUNC_FIND_PORT;
      end
      handle = ($urandom_range(9) == 0) ? $urandom : handle_pool[$urandom_range(pool_n - 1)];
      port = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) :
                                        port_pool[$urandom_range(15)];
      send_word(func, handle, port, 5'($urandom_range(31)), $urandom,
                16'($urandom_range(65535)));
    end
  endtask

  task automatic test_random_traffic;
    handle_pool[0] = 32'h0000_0000;
    handle_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_MAX; i++) handle_pool[i] = $urandom;
    port_pool[0] = 16'd0;
    port_pool[1] = 16'hFFFF;
    port_pool[2] = 16'd1;
    for (int i = 3; i < 16; i++) port_pool[i] = 16'($urandom_range(65535));
    run_segment(6, 15, 40, 200);
    run_segment(24, 10, 40, 200);
    // upsert-heavy over a wide pool fills the table and hits the drop path
    run_segment(POOL_MAX, 1, 70, 300);
    run_segment(POOL_MAX, 35, 30, 200);
    wait_drained();
    run_segment(64, 8, 40, 200);
    run_segment(6, 20, 40, 150);
    run_segment(24, 12, 40, 150);
    wait_drained();
  endtask

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_handle[k] = '0;
      tbl_port[k] = '0;
      tbl_known[k] = 1'b0;
      tbl_type[k] = '0;
      tbl_connected[k] = 1'b0;
      tbl_peer_ip[k] = '0;
      tbl_peer_port[k] = '0;
    end
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_full_table();
    test_random_traffic();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("%0t: timeout with %0d words pending", $time, pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
sv/sat_pkg.sv
sv/sat_mem.sv
sv/sat_cmp.sv
sv/socket_association_table_core.sv
bench/tb.sv
